FILE: rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersection block
// Widths of the fixed-point datapath, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int INDEX_WIDTH = 16;

  // Edge and offset vectors carry one extra bit.
  localparam int DIFF_W = COORD_WIDTH + 1;
  // Cross product terms are 35 bits and dot product sums 54 bits wide, each capped at 64.
  localparam int PROD_W = (2 * DIFF_W + 1 > 64) ? 64 : 2 * DIFF_W + 1;
  localparam int DOT_W  = (PROD_W + DIFF_W + 2 > 64) ? 64 : PROD_W + DIFF_W + 2;

  localparam int FRAC_W = 16;
  localparam int DIST_W = 32;
  localparam int BARY_W = 17;

  localparam int CFG_DATA_W  = (COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_T_LIMIT  = 3'd6;

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // One classified triangle handed from the front to the back.
  typedef struct packed {
    logic [DOT_W-1:0]       det;
    logic [DOT_W-1:0]       tn;
    logic [DOT_W-1:0]       un;
    logic [DOT_W-1:0]       vn;
    logic                   cand;
    logic                   new_ray;
    logic [INDEX_WIDTH-1:0] tri_id;
  } work_t;

endpackage

FILE: rtl/core/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: triangle setup
// Forms the edge vectors, both cross products and the four dot products on
// one shared multiplier, then normalizes the sign and classifies the hit.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  rti_pkg::vec_t                   v0,
  input  rti_pkg::vec_t                   v1,
  input  rti_pkg::vec_t                   v2,
  input  logic [rti_pkg::INDEX_WIDTH-1:0] tri_index,
  input  logic                            new_ray,
  input  rti_pkg::vec_t                   org,
  input  rti_pkg::vec_t                   dir,
  output logic                            q_push,
  output rti_pkg::work_t                  q_data,
  input  logic                            q_full
);
  import rti_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_EDGE = 4'b0010,
    F_MUL  = 4'b0100,
    F_EMIT = 4'b1000
  } fstate_t;

  typedef enum logic [2:0] {
    D_P   = 3'd0,
    D_Q   = 3'd1,
    D_DET = 3'd2,
    D_UN  = 3'd3,
    D_TN  = 3'd4,
    D_VN  = 3'd5
  } dest_t;

  fstate_t state;

  logic [INDEX_WIDTH-1:0] tri_r;
  logic                   nr_r;

  logic signed [DIFF_W-1:0] e1 [3];
  logic signed [DIFF_W-1:0] e2 [3];
  logic signed [DIFF_W-1:0] sv [3];
  logic signed [DIFF_W-1:0] dv [3];
  logic signed [PROD_W-1:0] pv [3];
  logic signed [PROD_W-1:0] qv [3];
  logic signed [DOT_W-1:0]  det, tn, un, vn;

  // Sequencer position: group 0 and 1 are the cross products (two terms per
  // component), groups 2 to 5 the dot products.
  logic [2:0] grp;
  logic [1:0] comp;
  logic       sub;
  logic       issue_done;

  logic signed [DOT_W-1:0] prod;
  dest_t                   pdest;
  logic [1:0]              pcomp;
  logic                    pneg;
  logic                    pvalid;

  logic signed [PROD_W-1:0] a_sel;
  logic signed [DIFF_W-1:0] b_sel;
  logic signed [PROD_W+DIFF_W-1:0] mfull;
  dest_t      d_sel;
  logic       n_sel;

  function automatic logic [1:0] inc3(input logic [1:0] i);
    logic [1:0] r;
    unique case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  logic [1:0] j1, j2;
  assign j1 = inc3(comp);
  assign j2 = inc3(j1);

  always_comb begin
    a_sel = '0;
    b_sel = '0;
    d_sel = D_P;
    n_sel = 1'b0;
    unique case (grp)
      3'd0: begin
        a_sel = PROD_W'(sub ? dv[j2] : dv[j1]);
        b_sel = sub ? e2[j1] : e2[j2];
        d_sel = D_P;
        n_sel = sub;
      end
      3'd1: begin
        a_sel = PROD_W'(sub ? sv[j2] : sv[j1]);
        b_sel = sub ? e1[j1] : e1[j2];
        d_sel = D_Q;
        n_sel = sub;
      end
      3'd2: begin
        a_sel = pv[comp];
        b_sel = e1[comp];
        d_sel = D_DET;
      end
      3'd3: begin
        a_sel = pv[comp];
        b_sel = sv[comp];
        d_sel = D_UN;
      end
      3'd4: begin
        a_sel = qv[comp];
        b_sel = e2[comp];
        d_sel = D_TN;
      end
      default: begin
        a_sel = qv[comp];
        b_sel = dv[comp];
        d_sel = D_VN;
      end
    endcase
  end

  assign mfull = a_sel * b_sel;

  // Sign normalization and hit classification of the finished sums.
  logic              dneg;
  logic [DOT_W-1:0]  nd, nt, nu, nv;
  logic [DOT_W:0]    uv_sum;
  logic              cand;

  always_comb begin
    dneg   = det[DOT_W-1];
    nd     = dneg ? -det : det;
    nt     = dneg ? -tn  : tn;
    nu     = dneg ? -un  : un;
    nv     = dneg ? -vn  : vn;
    uv_sum = {1'b0, nu} + {1'b0, nv};
    cand   = (nd != '0) && (nt != '0) && !nt[DOT_W-1] && !nu[DOT_W-1] &&
             !nv[DOT_W-1] && (uv_sum <= {1'b0, nd});
  end

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_EMIT) && !q_full;
  assign q_data = '{det: nd, tn: nt, un: nu, vn: nv, cand: cand,
                    new_ray: nr_r, tri_id: tri_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      pvalid <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_EDGE;
          end
        end
        F_EDGE: begin
          state <= F_MUL;
        end
        F_MUL: begin
          pvalid <= !issue_done;
          if (issue_done && !pvalid) begin
            state <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      tri_r  <= tri_index;
      nr_r   <= new_ray;
      e1[0] <= DIFF_W'(v1.x) - DIFF_W'(v0.x);
      e1[1] <= DIFF_W'(v1.y) - DIFF_W'(v0.y);
      e1[2] <= DIFF_W'(v1.z) - DIFF_W'(v0.z);
      e2[0] <= DIFF_W'(v2.x) - DIFF_W'(v0.x);
      e2[1] <= DIFF_W'(v2.y) - DIFF_W'(v0.y);
      e2[2] <= DIFF_W'(v2.z) - DIFF_W'(v0.z);
      sv[0] <= DIFF_W'(org.x) - DIFF_W'(v0.x);
      sv[1] <= DIFF_W'(org.y) - DIFF_W'(v0.y);
      sv[2] <= DIFF_W'(org.z) - DIFF_W'(v0.z);
      dv[0] <= DIFF_W'(dir.x);
      dv[1] <= DIFF_W'(dir.y);
      dv[2] <= DIFF_W'(dir.z);
    end

    if (state == F_EDGE) begin
      for (int c = 0; c < 3; c++) begin
        pv[c] <= '0;
        qv[c] <= '0;
      end
      det        <= '0;
      tn         <= '0;
      un         <= '0;
      vn         <= '0;
      grp        <= 3'd0;
      comp       <= 2'd0;
      sub        <= 1'b0;
      issue_done <= 1'b0;
    end

    if (state == F_MUL) begin
      if (!issue_done) begin
        prod  <= DOT_W'(mfull);
        pdest <= d_sel;
        pcomp <= comp;
        pneg  <= n_sel;
        if (grp < 3'd2 && !sub) begin
          sub <= 1'b1;
        end else begin
          sub <= 1'b0;
          if (comp == 2'd2) begin
            comp <= 2'd0;
            if (grp == 3'd5) begin
              issue_done <= 1'b1;
            end else begin
              grp <= grp + 3'd1;
            end
          end else begin
            comp <= comp + 2'd1;
          end
        end
      end
      if (pvalid) begin
        unique case (pdest)
          D_P:   pv[pcomp] <= pneg ? pv[pcomp] - PROD_W'(prod)
                                   : pv[pcomp] + PROD_W'(prod);
          D_Q:   qv[pcomp] <= pneg ? qv[pcomp] - PROD_W'(prod)
                                   : qv[pcomp] + PROD_W'(prod);
          D_DET: det <= det + prod;
          D_UN:  un  <= un + prod;
          D_TN:  tn  <= tn + prod;
          default: vn <= vn + prod;
        endcase
      end
    end
  end
endmodule

FILE: rtl/core/rti_queue.sv
// ----------------------------------------------------------------------------
// rti_queue: work queue between setup and division
// A small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module rti_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  rti_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd,
  output rti_pkg::work_t rd_data,
  output logic           empty
);
  import rti_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= bump(wptr);
      end
      if (rd && !empty) begin
        rptr <= bump(rptr);
      end
      count <= count + CNT_W'(wr && !full) - CNT_W'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wr_data;
    end
  end
endmodule

FILE: rtl/core/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back: division and closest-distance tracking
// Three restoring dividers produce t, u and v one bit a cycle; the result is
// compared against the running closest distance and held for the consumer.
// ----------------------------------------------------------------------------
module rti_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  rti_pkg::work_t                    q_data,
  output logic                              q_pop,
  input  logic [rti_pkg::DIST_W-1:0]        t_limit,
  output logic                              empty,
  input  logic                              pop,
  output logic                              hit,
  output logic                              nearer,
  output logic [rti_pkg::DIST_W-1:0]        dist_t,
  output logic [rti_pkg::BARY_W-1:0]        bary_u,
  output logic [rti_pkg::BARY_W-1:0]        bary_v,
  output logic [rti_pkg::INDEX_WIDTH-1:0]   tri_echo
);
  import rti_pkg::*;

  localparam int CNT_W = $clog2(DIST_W);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_DIV   = 3'b010,
    B_WRITE = 3'b100
  } bstate_t;

  bstate_t state;
  logic [DIST_W-1:0]      closest_t;
  logic                   out_valid;
  logic [CNT_W-1:0]       count;
  logic                   cand;
  logic [INDEX_WIDTH-1:0] tri_r;
  logic [DOT_W-1:0]       den;
  logic [DOT_W-1:0]       rem [3];
  logic [DIST_W-1:0]      quo [3];
  logic                   sat [3];

  logic [DOT_W-1:0] num [3];
  assign num[0] = q_data.tn;
  assign num[1] = q_data.un;
  assign num[2] = q_data.vn;

  logic [DIST_W-1:0] t_val;
  logic              slot_free;
  assign t_val     = sat[0] ? '1 : quo[0];
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      closest_t <= '1;
    end else begin
      if (state == B_WRITE && slot_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_data.new_ray) begin
              closest_t <= t_limit;
            end
            state <= q_data.cand ? B_DIV : B_WRITE;
          end
        end
        B_DIV: begin
          if (count == CNT_W'(DIST_W - 1)) begin
            state <= B_WRITE;
          end
        end
        B_WRITE: begin
          if (slot_free) begin
            if (cand && t_val < closest_t) begin
              closest_t <= t_val;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      cand  <= q_data.cand;
      tri_r <= q_data.tri_id;
      den   <= q_data.det;
      count <= '0;
      for (int n = 0; n < 3; n++) begin
        // The quotient needs more than 32 bits once num reaches det * 2^16.
        sat[n] <= {FRAC_W'(0), num[n]} >= {q_data.det, FRAC_W'(0)};
        rem[n] <= num[n] >> FRAC_W;
        quo[n] <= {num[n][FRAC_W-1:0], FRAC_W'(0)};
      end
    end

    if (state == B_DIV) begin
      count <= count + CNT_W'(1);
      for (int n = 0; n < 3; n++) begin
        logic [DOT_W:0] r2;
        r2 = {rem[n], quo[n][DIST_W-1]};
        if (r2 >= {1'b0, den}) begin
          rem[n] <= DOT_W'(r2 - {1'b0, den});
          quo[n] <= {quo[n][DIST_W-2:0], 1'b1};
        end else begin
          rem[n] <= r2[DOT_W-1:0];
          quo[n] <= {quo[n][DIST_W-2:0], 1'b0};
        end
      end
    end

    if (state == B_WRITE && slot_free) begin
      hit      <= cand;
      nearer   <= cand && (t_val < closest_t);
      dist_t   <= cand ? t_val : '0;
      bary_u   <= cand ? quo[1][BARY_W-1:0] : '0;
      bary_v   <= cand ? quo[2][BARY_W-1:0] : '0;
      tri_echo <= tri_r;
    end
  end
endmodule

FILE: rtl/core/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: ray against triangle stream intersection
// Tests the configured ray against each triangle and reports hit, distance,
// barycentric weights and whether the hit is the closest one so far.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------------------
//   triangle  push / full            v0_*, v1_*, v2_*, tri_index, new_ray
//   result    empty / pop            hit, nearer, dist_t, bary_u, bary_v,
//                                    tri_echo
//   config    cfg_write              cfg_index, cfg_data
//
// The front works on one triangle at a time: the accepting edge forms the
// edge vectors, a clearing state resets the sums, 24 products pass through a
// single shared multiplier and then drain from its product register, the
// emit state classifies and hands the work to the queue, and the front then
// returns to idle to wait for the next push. The back also takes one triangle
// at a time and runs its three bit-serial 32-step dividers only for a hitting
// triangle; a miss goes straight to the result write. Reset is synchronous; it
// empties the queue and the result slot and restores the register defaults. A
// stalled result consumer fills the two-entry work queue, after which full
// stays high.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_z,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_z,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_z,
  input  logic [rti_pkg::INDEX_WIDTH-1:0]        tri_index,
  input  logic                                  new_ray,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  hit,
  output logic                                  nearer,
  output logic [rti_pkg::DIST_W-1:0]             dist_t,
  output logic [rti_pkg::BARY_W-1:0]             bary_u,
  output logic [rti_pkg::BARY_W-1:0]             bary_v,
  output logic [rti_pkg::INDEX_WIDTH-1:0]        tri_echo,
  input  logic                                  cfg_write,
  input  logic [rti_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rti_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import rti_pkg::*;

  // Ray registers. The direction defaults to +z with a z component of 256.
  vec_t              org;
  vec_t              dir;
  logic [DIST_W-1:0] t_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      org     <= '0;
      dir     <= '{x: '0, y: '0, z: COORD_WIDTH'(256)};
      t_limit <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: org.x   <= cfg_data[COORD_WIDTH-1:0];
        CFG_ORIGIN_Y: org.y   <= cfg_data[COORD_WIDTH-1:0];
        CFG_ORIGIN_Z: org.z   <= cfg_data[COORD_WIDTH-1:0];
        CFG_DIR_X:    dir.x   <= cfg_data[COORD_WIDTH-1:0];
        CFG_DIR_Y:    dir.y   <= cfg_data[COORD_WIDTH-1:0];
        CFG_DIR_Z:    dir.z   <= cfg_data[COORD_WIDTH-1:0];
        CFG_T_LIMIT:  t_limit <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  vec_t  v0, v1, v2;
  assign v0 = '{x: v0_x, y: v0_y, z: v0_z};
  assign v1 = '{x: v1_x, y: v1_y, z: v1_z};
  assign v2 = '{x: v2_x, y: v2_y, z: v2_z};

  // Front: setup and classification, one triangle at a time.
  work_t wq_in, wq_out;
  logic  wq_push, wq_full, wq_pop, wq_empty;

  rti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .v0        (v0),
    .v1        (v1),
    .v2        (v2),
    .tri_index (tri_index),
    .new_ray   (new_ray),
    .org       (org),
    .dir       (dir),
    .q_push    (wq_push),
    .q_data    (wq_in),
    .q_full    (wq_full)
  );

  // The queue decouples setup from division.
  rti_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wq_push),
    .wr_data (wq_in),
    .full    (wq_full),
    .rd      (wq_pop),
    .rd_data (wq_out),
    .empty   (wq_empty)
  );

  // Back: divides, tracks the closest hit and holds the result transaction.
  rti_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (wq_empty),
    .q_data   (wq_out),
    .q_pop    (wq_pop),
    .t_limit  (t_limit),
    .empty    (empty),
    .pop      (pop),
    .hit      (hit),
    .nearer   (nearer),
    .dist_t   (dist_t),
    .bary_u   (bary_u),
    .bary_v   (bary_v),
    .tri_echo (tri_echo)
  );
endmodule

FILE: tb/ray_triangle_intersect_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb: self-checking testbench of the ray/triangle block
// Streams directed and random triangles against several ray settings, models
// the intersection test and closest-hit tracking, and checks every result.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  // One expected or observed result transaction.
  typedef struct {
    logic                   hit;
    logic                   nearer;
    logic [DIST_W-1:0]      t_dist;
    logic [BARY_W-1:0]      u;
    logic [BARY_W-1:0]      v;
    logic [INDEX_WIDTH-1:0] tri_id;
  } isect_t;

  // One triangle transaction: nine coordinates in v0, v1, v2 order.
  typedef struct {
    coord_t                 c[9];
    logic [INDEX_WIDTH-1:0] tri_id;
    logic                   fresh;
  } tri_t;

  // The scoreboard keeps its own copy of the ray registers and of the
  // running closest distance, and predicts one result per triangle.
  class isect_scoreboard;
    coord_t            org[3];
    coord_t            dir[3];
    logic [DIST_W-1:0] t_lim;
    logic [DIST_W-1:0] closest;
    isect_t            pending[$];
    int                mismatches;
    int                checked;
    int                hits;
    int                nearers;

    function new();
      org = '{0, 0, 0};
      dir = '{0, 0, 256};
      t_lim = '1;
      closest = '1;
      mismatches = 0;
      checked = 0;
      hits = 0;
      nearers = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_ORIGIN_X: org[0] = d[COORD_WIDTH-1:0];
        CFG_ORIGIN_Y: org[1] = d[COORD_WIDTH-1:0];
        CFG_ORIGIN_Z: org[2] = d[COORD_WIDTH-1:0];
        CFG_DIR_X:    dir[0] = d[COORD_WIDTH-1:0];
        CFG_DIR_Y:    dir[1] = d[COORD_WIDTH-1:0];
        CFG_DIR_Z:    dir[2] = d[COORD_WIDTH-1:0];
        CFG_T_LIMIT:  t_lim = d[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(num * 2^16 / den) with saturation; both operands are nonnegative.
    function logic [DIST_W-1:0] q16_ratio(longint num, longint den);
      logic [127:0] wide;
      if (num / den > 65535) return '1;
      wide = {64'd0, num} << FRAC_W;
      return DIST_W'(wide / {64'd0, den});
    endfunction

    function void note_triangle(tri_t tr);
      longint e1[3], e2[3], s[3], p[3], q[3], d[3];
      longint det, tn, un, vn;
      isect_t r;
      if (tr.fresh) closest = t_lim;
      for (int k = 0; k < 3; k++) begin
        e1[k] = longint'(tr.c[3+k]) - longint'(tr.c[k]);
        e2[k] = longint'(tr.c[6+k]) - longint'(tr.c[k]);
        s[k]  = longint'(org[k]) - longint'(tr.c[k]);
        d[k]  = longint'(dir[k]);
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
      tn  = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
      un  = p[0]*s[0]  + p[1]*s[1]  + p[2]*s[2];
      vn  = q[0]*d[0]  + q[1]*d[1]  + q[2]*d[2];
      // Fold the sign of the determinant into the numerators.
      if (det < 0) begin
        det = -det;
        tn = -tn;
        un = -un;
        vn = -vn;
      end
      r = '{hit: 0, nearer: 0, t_dist: 0, u: 0, v: 0, tri_id: tr.tri_id};
      if (det != 0 && tn > 0 && un >= 0 && vn >= 0 && un + vn <= det) begin
        r.hit  = 1'b1;
        r.t_dist = q16_ratio(tn, det);
        r.u    = BARY_W'(q16_ratio(un, det));
        r.v    = BARY_W'(q16_ratio(vn, det));
        hits++;
        if (r.t_dist < closest) begin
          r.nearer = 1'b1;
          closest = r.t_dist;
          nearers++;
        end
      end
      pending = {pending, r};
    endfunction

    function void check_result(isect_t got);
      isect_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result for triangle %0d with nothing expected", got.tri_id);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.nearer !== want.nearer || got.t_dist !== want.t_dist ||
          got.u !== want.u || got.v !== want.v || got.tri_id !== want.tri_id) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp hit=%b nearer=%b t=%h u=%h v=%h tri=%h, got %b %b %h %h %h %h",
                   want.hit, want.nearer, want.t_dist, want.u, want.v, want.tri_id,
                   got.hit, got.nearer, got.t_dist, got.u, got.v, got.tri_id);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  coord_t v0_x = '0, v0_y = '0, v0_z = '0;
  coord_t v1_x = '0, v1_y = '0, v1_z = '0;
  coord_t v2_x = '0, v2_y = '0, v2_z = '0;
  logic [INDEX_WIDTH-1:0] tri_index = '0;
  logic new_ray = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic hit, nearer;
  logic [DIST_W-1:0] dist_t;
  logic [BARY_W-1:0] bary_u, bary_v;
  logic [INDEX_WIDTH-1:0] tri_echo;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  isect_scoreboard sb = new();

  // Idle and stall percentages of the current phase, and the long hold-off.
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  bit input_busy = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #5 clk = ~clk;

  ray_triangle_intersect DUT (.*);

  // Result consumer: pop changes at the falling edge only. A hold-off request
  // keeps pop low for a long stretch so that the work queue backs up.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_request && hold_left == 0) begin
      hold_left = 400;
      hold_request = 0;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: transactions on both channels are taken at the rising edge.
  always @(posedge clk) begin
    isect_t got;
    if (!rst) begin
      if (push && !full) begin
        idle_cycles = 0;
      end
      if (pop && !empty) begin
        got = '{hit: hit, nearer: nearer, t_dist: dist_t, u: bary_u, v: bary_v,
                tri_id: tri_echo};
        sb.check_result(got);
        idle_cycles = 0;
      end else if (push || sb.pending.size() > 0 || input_busy) begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
          $display("FAIL ray_triangle_intersect");
          $finish;
        end
      end
    end
  end

  // Offers one triangle from a falling edge on and returns once accepted.
  // full only moves at rising edges, so its value at the falling edge is
  // the one the block sees at the next rising edge.
  task automatic send_triangle(tri_t tr);
    bit taken;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    {v0_x, v0_y, v0_z} <= {tr.c[0], tr.c[1], tr.c[2]};
    {v1_x, v1_y, v1_z} <= {tr.c[3], tr.c[4], tr.c[5]};
    {v2_x, v2_y, v2_z} <= {tr.c[6], tr.c[7], tr.c[8]};
    tri_index <= tr.tri_id;
    new_ray <= tr.fresh;
    push <= 1'b1;
    do begin
      #1;
      taken = !full;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    sb.note_triangle(tr);
    sent++;
  endtask

  // Lets the block drain completely before its registers change.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  // Coordinates carry random upper bits, which the block must ignore.
  task automatic write_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                           logic [31:0] lim);
    write_reg(CFG_ORIGIN_X, {16'($urandom), 16'(ox)});
    write_reg(CFG_ORIGIN_Y, {16'($urandom), 16'(oy)});
    write_reg(CFG_ORIGIN_Z, {16'($urandom), 16'(oz)});
    write_reg(CFG_DIR_X, {16'($urandom), 16'(dx)});
    write_reg(CFG_DIR_Y, {16'($urandom), 16'(dy)});
    write_reg(CFG_DIR_Z, {16'($urandom), 16'(dz)});
    write_reg(CFG_T_LIMIT, lim);
  endtask

  function automatic int clamp16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic int srand(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // A triangle built from nine given coordinates, with a random index.
  function automatic tri_t flat_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                    int x2, int y2, int z2, bit fresh);
    tri_t tr;
    tr.c = '{coord_t'(x0), coord_t'(y0), coord_t'(z0), coord_t'(x1), coord_t'(y1),
             coord_t'(z1), coord_t'(x2), coord_t'(y2), coord_t'(z2)};
    tr.tri_id = INDEX_WIDTH'($urandom);
    tr.fresh = fresh;
    return tr;
  endfunction

  // Most random triangles are built around a point on the current ray so
  // that hits, edge cases and near misses are common; the rest is noise.
  function automatic tri_t random_tri();
    tri_t tr;
    int pt[3], a[3], b[3], tk, span;
    tr.tri_id = INDEX_WIDTH'($urandom);
    tr.fresh = ($urandom_range(9) == 0);
    if ($urandom_range(99) < 25) begin
      foreach (tr.c[k]) tr.c[k] = coord_t'($urandom);
      return tr;
    end
    tk = int'($urandom_range(160)) - 16;
    span = ($urandom_range(3) == 0) ? 4000 : 600;
    for (int k = 0; k < 3; k++) begin
      pt[k] = clamp16(int'(sb.org[k]) + (int'(sb.dir[k]) * tk) / 16);
      a[k] = srand(span);
      b[k] = srand(span);
    end
    for (int k = 0; k < 3; k++) begin
      tr.c[k]   = coord_t'(clamp16(pt[k] + a[k]));
      tr.c[3+k] = coord_t'(clamp16(pt[k] + b[k]));
      // Centroid at the ray point, with jitter that pushes it off now and then.
      tr.c[6+k] = coord_t'(clamp16(pt[k] - a[k] - b[k] + srand(span / 2)));
    end
    return tr;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset ray: origin at zero looking along +z.
    send_triangle(flat_tri(-256, -256, 512, 512, -256, 512, -256, 512, 512, 1));
    send_triangle(flat_tri(-256, -256, 256, 512, -256, 256, -256, 512, 256, 0));
    send_triangle(flat_tri(-256, -256, 768, 512, -256, 768, -256, 512, 768, 0));
    send_triangle(flat_tri(-256, -256, -256, 512, -256, -256, -256, 512, -256, 0));
    send_triangle(flat_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(flat_tri(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 0));
    send_triangle(flat_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, 1));
    send_triangle(flat_tri(-32768, 32767, 32767, 32767, -32768, 32767,
                           -32768, -32768, 256, 0));
    send_triangle(flat_tri(0, -256, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(flat_tri(0, 0, 384, 256, 0, 384, 0, 256, 384, 0));
    send_triangle(flat_tri(-256, 0, 384, 256, 0, 384, 0, 256, 384, 0));
    send_triangle(flat_tri(256, 0, 300, 0, 256, 300, 0, 0, 300, 0));
    send_triangle(flat_tri(1, 1, 1, 2, 1, 1, 1, 2, 1, 0));
    wait_drained();

    // A nearly zero direction gives large Q16.16 distances, and a
    // zero direction makes every determinant zero.
    write_ray(0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF);
    send_triangle(flat_tri(-256, -256, 32767, 512, -256, 32767, -256, 512, 32767, 1));
    send_triangle(flat_tri(-256, -256, 1, 512, -256, 1, -256, 512, 1, 0));
    wait_drained();
    write_ray(0, 0, 0, 0, 0, 0, 32'h0001_0000);
    send_triangle(flat_tri(-256, -256, 512, 512, -256, 512, -256, 512, 512, 1));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 6)
        write_ray(-32768, -32768, -32768, 32767, 32767, 32767, 32'h0);
      else if (ph == 7)
        write_ray(32767, 32767, 32767, -32768, -32768, -32768, 32'hFFFF_FFFF);
      else
        write_ray(srand(2000), srand(2000), srand(2000), srand(512), srand(512),
                  srand(512), ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : $urandom);
      input_busy = 1;
      // The consumer holds off early in the first phase while items keep coming.
      if (ph == 0) hold_request = 1;
      for (int n = 0; n < 235; n++) send_triangle(random_tri());
      input_busy = 0;
      wait_drained();
      idle_pct = 0;
      stall_pct = 0;
    end

    $display("Ran %0d triangles over several ray settings and idle patterns.", sent);
    $display("Checked %0d results, %0d hits, %0d nearer hits, %0d mismatches.",
             sb.checked, sb.hits, sb.nearers, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS ray_triangle_intersect");
    end else begin
      $display("FAIL ray_triangle_intersect");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect.sv
tb/ray_triangle_intersect_tb.sv
